FILE: sv/json_token_scanner_unit_defines.svh
// Assertion macros shared by the token scanner RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef JSON_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define JSON_TOKEN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/jts_pkg.sv
// Shared types, token/error codes and keyword tables of the token scanner.
// No dependencies.
package jts_pkg;

    // token kinds
    localparam logic [3:0] KIND_LBRACKET = 4'd0;
    localparam logic [3:0] KIND_RBRACKET = 4'd1;
    localparam logic [3:0] KIND_LBRACE   = 4'd2;
    localparam logic [3:0] KIND_RBRACE   = 4'd3;
    localparam logic [3:0] KIND_COMMA    = 4'd4;
    localparam logic [3:0] KIND_COLON    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_TRUE     = 4'd8;
    localparam logic [3:0] KIND_FALSE    = 4'd9;
    localparam logic [3:0] KIND_NULL     = 4'd10;
    localparam logic [3:0] KIND_ERROR    = 4'd11;
    localparam logic [3:0] KIND_END      = 4'd12;

    // error kinds
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNTERM_STR = 3'd1;
    localparam logic [2:0] ERR_BAD_NUMBER = 3'd2;
    localparam logic [2:0] ERR_UNK_WORD   = 3'd3;
    localparam logic [2:0] ERR_UNEXP_CHAR = 3'd4;
    localparam logic [2:0] ERR_UNEXP_END  = 3'd5;

    // result queue
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = 2;
    localparam int OUT_LVL_BITS = 3;

    localparam int KW_COUNT = 6;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  err;
        logic [15:0] line;
        logic        last;
    } result_t;

    // results caused by one input word, packed towards r0
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } scan_res_t;

    // keyword text, character 0 in the lowest byte
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [39:0] txt;
        case (k)
            3'd0:    txt = 40'h00_65_75_72_74; // true
            3'd1:    txt = 40'h00_45_55_52_54; // TRUE
            3'd2:    txt = 40'h65_73_6C_61_66; // false
            3'd3:    txt = 40'h45_53_4C_41_46; // FALSE
            3'd4:    txt = 40'h00_6C_6C_75_6E; // null
            3'd5:    txt = 40'h00_4C_4C_55_4E; // NULL
            default: txt = 40'h0;
        endcase
        if (i > 3'd4)
            return 8'h00;
        return txt[{i, 3'b000} +: 8];
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        case (k)
            3'd2, 3'd3: return 3'd5;
            default:    return 3'd4;
        endcase
    endfunction

    function automatic logic [3:0] kw_kind(input logic [2:0] k);
        case (k)
            3'd0, 3'd1: return KIND_TRUE;
            3'd2, 3'd3: return KIND_FALSE;
            default:    return KIND_NULL;
        endcase
    endfunction

endpackage

FILE: sv/jts_scan_core.sv
// Scanner state and the decode of one byte in two scan passes.
// Depends on jts_pkg and json_token_scanner_unit_defines.svh.
`include "json_token_scanner_unit_defines.svh"

module jts_scan_core #(
    parameter int LINE_COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          char_byte,
    input  logic                end_of_input,
    output jts_pkg::scan_res_t  res
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_EMARK,
        MODE_ESIGN,
        MODE_EXP,
        MODE_WORD,
        MODE_SKIP
    } mode_t;

    typedef struct packed {
        logic                       emit;
        logic [3:0]                 kind;
        logic [2:0]                 err;
        logic                       rescan;
        mode_t                      mode;
        logic [5:0]                 cands;
        logic [2:0]                 wlen;
        logic [LINE_COUNT_BITS-1:0] line;
    } pass_t;

    mode_t                      mode_reg,     mode_next;
    logic [5:0]                 cands_reg,    cands_next;
    logic [2:0]                 wlen_reg,     wlen_next;
    logic [LINE_COUNT_BITS-1:0] line_reg,     line_next;
    logic                       finished_reg, finished_next;

    pass_t p1, p2;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= "a") && (l <= "z");
    endfunction

    function automatic logic [15:0] line16(input logic [LINE_COUNT_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[15:0];
    endfunction

    // drop candidates that cannot take this letter at this position
    function automatic logic [5:0] letter_cands(input logic [5:0] cands,
                                                input logic [2:0] wlen,
                                                input logic [7:0] c);
        logic [5:0] r;
        r = cands;
        for (int k = 0; k < jts_pkg::KW_COUNT; k++) begin
            if ((wlen >= jts_pkg::kw_len(3'(k))) || (jts_pkg::kw_char(3'(k), wlen) != c))
                r[k] = 1'b0;
        end
        return r;
    endfunction

    // keyword kind of the finished word, or error for an unknown word
    function automatic logic [3:0] close_kind(input logic [5:0] cands, input logic [2:0] wlen);
        logic [3:0] kind;
        kind = jts_pkg::KIND_ERROR;
        for (int k = jts_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (cands[k] && (jts_pkg::kw_len(3'(k)) == wlen))
                kind = jts_pkg::kw_kind(3'(k));
        end
        return kind;
    endfunction

    function automatic pass_t do_pass(input mode_t m, input logic [5:0] cands,
                                      input logic [2:0] wlen,
                                      input logic [LINE_COUNT_BITS-1:0] line,
                                      input logic [7:0] c);
        pass_t p;
        logic  num_end;
        p        = '0;
        p.mode   = m;
        p.cands  = cands;
        p.wlen   = wlen;
        p.line   = line;
        p.kind   = jts_pkg::KIND_ERROR;
        p.err    = jts_pkg::ERR_NONE;
        num_end  = 1'b0;
        case (m)
            MODE_IDLE:
            begin
                if ((c == " ") || (c == "\t") || (c == "\r")) begin
                end else if (c == "\n") begin
                    if (line != '1)
                        p.line = line + 1'b1;
                end else if (c == "\"") begin
                    p.mode = MODE_STR;
                end else if (is_digit(c)) begin
                    p.mode = MODE_INT;
                end else if (c == "[") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_LBRACKET;
                end else if (c == "]") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_RBRACKET;
                end else if (c == "{") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_LBRACE;
                end else if (c == "}") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_RBRACE;
                end else if (c == ",") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_COMMA;
                end else if (c == ":") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_COLON;
                end else if (is_alpha(c)) begin
                    p.mode  = MODE_WORD;
                    p.cands = letter_cands(6'h3F, 3'd0, c);
                    p.wlen  = 3'd1;
                end else begin
                    p.emit = 1'b1;
                    p.err  = jts_pkg::ERR_UNEXP_CHAR;
                    p.mode = MODE_SKIP;
                end
            end
            MODE_STR:
            begin
                if (c == "\"") begin
                    p.emit = 1'b1; p.kind = jts_pkg::KIND_STRING; p.mode = MODE_IDLE;
                end else if ((c == ",") || (c == ":") || (c == "\n")) begin
                    p.emit   = 1'b1;
                    p.err    = jts_pkg::ERR_UNTERM_STR;
                    p.mode   = MODE_SKIP;
                    p.rescan = 1'b1;
                end
            end
            MODE_INT, MODE_FRAC:
            begin
                if (is_digit(c)) begin
                end else if ((c == ".") && (m == MODE_INT)) begin
                    p.mode = MODE_DOT;
                end else if ((c == "e") || (c == "E")) begin
                    p.mode = MODE_EMARK;
                end else begin
                    num_end = 1'b1;
                end
            end
            MODE_DOT, MODE_EMARK, MODE_ESIGN:
            begin
                if (is_digit(c)) begin
                    p.mode = (m == MODE_DOT) ? MODE_FRAC : MODE_EXP;
                end else if ((m == MODE_EMARK) && ((c == "+") || (c == "-"))) begin
                    p.mode = MODE_ESIGN;
                end else begin
                    p.emit   = 1'b1;
                    p.err    = jts_pkg::ERR_BAD_NUMBER;
                    p.mode   = MODE_SKIP;
                    p.rescan = 1'b1;
                end
            end
            MODE_EXP:
            begin
                if (!is_digit(c))
                    num_end = 1'b1;
            end
            MODE_WORD:
            begin
                if (is_alpha(c)) begin
                    p.cands = letter_cands(cands, wlen, c);
                    p.wlen  = (wlen < 3'd7) ? wlen + 3'd1 : wlen;
                end else begin
                    p.emit   = 1'b1;
                    p.rescan = 1'b1;
                    p.kind   = close_kind(cands, wlen);
                    if (p.kind == jts_pkg::KIND_ERROR) begin
                        p.err  = jts_pkg::ERR_UNK_WORD;
                        p.mode = MODE_SKIP;
                    end else begin
                        p.mode = MODE_IDLE;
                    end
                end
            end
            default:
            begin
                // discard up to the line feed
                if (c == "\n") begin
                    if (line != '1)
                        p.line = line + 1'b1;
                    p.mode = MODE_IDLE;
                end
            end
        endcase
        if (num_end) begin
            p.emit = 1'b1;
            if (is_alpha(c)) begin
                p.err  = jts_pkg::ERR_BAD_NUMBER;
                p.mode = MODE_SKIP;
            end else begin
                p.kind   = jts_pkg::KIND_NUMBER;
                p.mode   = MODE_IDLE;
                p.rescan = 1'b1;
            end
        end
        return p;
    endfunction

    always_comb
    begin
        logic       e0, e1;
        logic [3:0] k0, k1;
        logic [2:0] x0, x1;
        logic [15:0] l0, l1;

        p1 = do_pass(mode_reg, cands_reg, wlen_reg, line_reg, char_byte);
        p2 = do_pass(p1.mode, p1.cands, p1.wlen, p1.line, char_byte);

        mode_next     = mode_reg;
        cands_next    = cands_reg;
        wlen_next     = wlen_reg;
        line_next     = line_reg;
        finished_next = finished_reg;

        e0 = 1'b0; k0 = jts_pkg::KIND_ERROR; x0 = jts_pkg::ERR_NONE; l0 = line16(line_reg);
        e1 = 1'b0; k1 = jts_pkg::KIND_END;   x1 = jts_pkg::ERR_NONE; l1 = line16(line_reg);

        if (finished_reg) begin
            // nothing after the end token
        end else if (end_of_input) begin
            e1 = 1'b1;
            case (mode_reg)
                MODE_STR:
                begin
                    e0 = 1'b1; x0 = jts_pkg::ERR_UNTERM_STR;
                end
                MODE_INT, MODE_FRAC, MODE_EXP:
                begin
                    e0 = 1'b1; k0 = jts_pkg::KIND_NUMBER;
                end
                MODE_DOT, MODE_EMARK, MODE_ESIGN:
                begin
                    e0 = 1'b1; x0 = jts_pkg::ERR_UNEXP_END;
                end
                MODE_WORD:
                begin
                    e0 = 1'b1;
                    k0 = close_kind(cands_reg, wlen_reg);
                    if (k0 == jts_pkg::KIND_ERROR)
                        x0 = jts_pkg::ERR_UNK_WORD;
                end
                default:
                begin
                end
            endcase
            mode_next     = MODE_IDLE;
            finished_next = 1'b1;
        end else begin
            e0 = p1.emit; k0 = p1.kind; x0 = p1.err;
            e1 = p1.rescan && p2.emit; k1 = p2.kind; x1 = p2.err; l1 = line16(p1.line);
            if (p1.rescan) begin
                mode_next = p2.mode; cands_next = p2.cands;
                wlen_next = p2.wlen; line_next  = p2.line;
            end else begin
                mode_next = p1.mode; cands_next = p1.cands;
                wlen_next = p1.wlen; line_next  = p1.line;
            end
        end

        // compact the results towards r0
        res    = '0;
        res.n  = 2'(e0) + 2'(e1);
        if (e0) begin
            res.r0 = '{kind: k0, err: x0, line: l0, last: !e1};
            res.r1 = '{kind: k1, err: x1, line: l1, last: 1'b1};
        end else begin
            res.r0 = '{kind: k1, err: x1, line: l1, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= MODE_IDLE;
            cands_reg    <= 6'h3F;
            wlen_reg     <= 3'd0;
            line_reg     <= LINE_COUNT_BITS'(1);
            finished_reg <= 1'b0;
        end else if (step) begin
            mode_reg     <= mode_next;
            cands_reg    <= cands_next;
            wlen_reg     <= wlen_next;
            line_reg     <= line_next;
            finished_reg <= finished_next;
        end
    end

    `JTS_ASSERT_NOW(a_quiet_after_end, finished_reg, res.n == 2'd0, "result after end token")
    `JTS_ASSERT_NEXT(a_end_sets_finished, step && end_of_input, finished_reg,
                     "end of input did not finish scanning")
    `JTS_ASSERT_NOW(a_line_nonzero, 1'b1, line_reg != '0, "line count reached zero")

endmodule

FILE: sv/jts_out_fifo.sv
// Four-entry result queue, up to two results pushed and one popped per cycle.
// Depends on jts_pkg and json_token_scanner_unit_defines.svh.
`include "json_token_scanner_unit_defines.svh"

module jts_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          push_n,
    input  jts_pkg::result_t                    push_d0,
    input  jts_pkg::result_t                    push_d1,
    input  logic                                pop,
    output logic                                head_valid,
    output jts_pkg::result_t                    head,
    output logic [jts_pkg::OUT_LVL_BITS-1:0]    level
);

    jts_pkg::result_t                   slot_reg [jts_pkg::OUT_DEPTH];
    logic [jts_pkg::OUT_PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [jts_pkg::OUT_LVL_BITS-1:0]   level_reg;
    logic [jts_pkg::OUT_PTR_BITS-1:0]   wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign head_valid = (level_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            slot_reg[wr_ptr_reg] <= push_d0;
        if (push_n == 2'd2)
            slot_reg[wr_ptr_inc] <= push_d1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + jts_pkg::OUT_PTR_BITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + jts_pkg::OUT_PTR_BITS'(pop);
            level_reg  <= level_reg + jts_pkg::OUT_LVL_BITS'(push_n)
                                    - jts_pkg::OUT_LVL_BITS'(pop);
        end
    end

    `JTS_ASSERT_NOW(a_no_overflow, 1'b1,
        (level_reg + jts_pkg::OUT_LVL_BITS'(push_n) - jts_pkg::OUT_LVL_BITS'(pop))
            <= jts_pkg::OUT_LVL_BITS'(jts_pkg::OUT_DEPTH),
        "result queue overflow")
    `JTS_ASSERT_NOW(a_no_underflow, pop, level_reg != '0, "pop from empty result queue")
    `JTS_ASSERT_NEXT(a_push_shows, (level_reg == '0) && (push_n != 2'd0) && !pop,
        head_valid, "pushed result not visible")

endmodule

FILE: sv/json_token_scanner_unit.sv
// JSON token scanner top level (input register, scan core, result queue); needs jts_pkg,
//   jts_scan_core, jts_out_fifo and the defines header.
// A taken byte waits in the input register and is scanned and queued once the queue has room.
// Throughput: one byte per cycle while the queue holds at most two results after this
//   cycle's pop; two-result bytes fill it at one result word per clock out.
// Reset (rst_n, async, active low): idle mode, line one, queue empty, not finished.
`include "json_token_scanner_unit_defines.svh"

module json_token_scanner_unit #(
    parameter int LINE_COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream: one source byte per word
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] end_of_input
    // result stream: one token per word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] token_kind, [6:4] error_kind,
                                        // [22:7] line_number, [23] zero
    output logic        m_axis_tlast    // last result of the input byte
);

    // Input register: holds the accepted byte until the queue has room for
    // its worst case of two results.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    logic                                   step;
    logic                                   room;
    logic                                   pop;
    logic [jts_pkg::OUT_LVL_BITS-1:0]       level;
    jts_pkg::scan_res_t                     res;
    jts_pkg::result_t                       head;

    assign pop  = m_axis_tvalid && m_axis_tready;
    // after this cycle's pop at most two slots may be in use
    assign room = (level - jts_pkg::OUT_LVL_BITS'(pop))
                  <= jts_pkg::OUT_LVL_BITS'(jts_pkg::OUT_DEPTH - 2);
    assign step = in_valid_reg && room;

    // the register is free or is being drained this cycle
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
    end

    // Scan both passes of the byte and update the scanner state on step.
    jts_scan_core #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .res          (res)
    );

    // Queue the results; it decouples the scanner from output stalls.
    jts_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (step ? res.n : 2'd0),
        .push_d0    (res.r0),
        .push_d1    (res.r1),
        .pop        (pop),
        .head_valid (m_axis_tvalid),
        .head       (head),
        .level      (level)
    );

    assign m_axis_tdata = {1'b0, head.line, head.err, head.kind};
    assign m_axis_tlast = head.last;

    `JTS_ASSERT_NOW(a_err_iff_error_kind, m_axis_tvalid,
        (head.kind == jts_pkg::KIND_ERROR) == (head.err != jts_pkg::ERR_NONE),
        "error code does not match token kind")
    `JTS_ASSERT_NEXT(a_held_byte_stays, in_valid_reg && !step,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_eoi_reg),
        "waiting input byte lost or changed")
    `JTS_ASSERT_NOW(a_step_has_room, step, level <= jts_pkg::OUT_LVL_BITS'(jts_pkg::OUT_DEPTH),
        "scan step without queue room")

endmodule

FILE: tb/sv/tb_json_token_scanner_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for json_token_scanner_unit: byte stream in, token words out,
// checked against a behavioural scanner held in a small scoreboard class.
// Depends on jts_pkg (token and error codes, result_t) and the RTL of the unit.

module tb_json_token_scanner_unit;

    // source characters the scanner treats specially
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;

    localparam int  CLK_HALF_NS   = 6;
    localparam int  RANDOM_BYTES  = 420;
    localparam int  LF_FLOOD      = 40;      // a run of line feeds sent back to back
    localparam int  DRAIN_CYCLES  = 8;       // margin after the last drain
    localparam longint LIMIT_NS   = 64'd12_000_000;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_TWO_IN_THREE, READY_SPARSE} ready_style_e;

    // ------------------------------------------------------------------
    // Scoreboard: tracks scanner state, predicts token words, checks them
    // ------------------------------------------------------------------
    class token_scoreboard;

        typedef enum logic [3:0] {
            S_IDLE, S_STRING, S_INT, S_DOT, S_FRAC, S_EMARK, S_ESIGN, S_EXP, S_WORD, S_DISCARD
        } scan_state_e;

        scan_state_e mode;
        logic [15:0] line_no;
        logic [5:0]  kw_live;
        logic [2:0]  word_len;
        bit          done;

        string       kw_text [6];
        logic [3:0]  kw_tok [6];

        jts_pkg::result_t step_res[$];
        jts_pkg::result_t token_q[$];
        int          errors;

        function new();
            kw_text  = '{"true", "TRUE", "false", "FALSE", "null", "NULL"};
            kw_tok   = '{jts_pkg::KIND_TRUE, jts_pkg::KIND_TRUE, jts_pkg::KIND_FALSE,
                         jts_pkg::KIND_FALSE, jts_pkg::KIND_NULL, jts_pkg::KIND_NULL};
            mode     = S_IDLE;
            line_no  = 16'd1;
            kw_live  = 6'h3F;
            word_len = 3'd0;
            done     = 1'b0;
            errors   = 0;
        endfunction

        function int outstanding();
            return token_q.size();
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c | 8'h20) >= CH_LOWER_A && (c | 8'h20) <= CH_LOWER_Z;
        endfunction

        function void emit_token(logic [3:0] kind, logic [2:0] err);
            jts_pkg::result_t r;
            if (step_res.size() >= 2)
                return;
            r.kind = kind;
            r.err  = err;
            r.line = line_no;
            r.last = 1'b0;
            step_res.push_back(r);
        endfunction

        function void bump_line();
            if (line_no != 16'hFFFF)
                line_no++;
        endfunction

        // drop every keyword whose spelling disagrees at this position
        function void add_letter(logic [7:0] c);
            for (int k = 0; k < 6; k++)
                if (word_len >= kw_text[k].len() || kw_text[k][word_len] != c)
                    kw_live[k] = 1'b0;
            if (word_len < 3'd7)
                word_len++;
        endfunction

        function bit close_word();
            for (int k = 0; k < 6; k++)
                if (kw_live[k] && kw_text[k].len() == word_len)
                begin
                    emit_token(kw_tok[k], jts_pkg::ERR_NONE);
                    return 1'b1;
                end
            emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_UNK_WORD);
            return 1'b0;
        endfunction

        // one pass over a byte; returns 1 when the byte has to be scanned again
        function bit scan_byte(logic [7:0] c);
            bit number_done;
            number_done = 1'b0;
            case (mode)
                S_IDLE:
                begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
                        return 1'b0;
                    if (c == CH_LF)
                    begin
                        bump_line();
                        return 1'b0;
                    end
                    if (c == CH_QUOTE)
                    begin
                        mode = S_STRING;
                        return 1'b0;
                    end
                    if (is_digit(c))
                    begin
                        mode = S_INT;
                        return 1'b0;
                    end
                    case (c)
                        CH_LSQUARE: emit_token(jts_pkg::KIND_LBRACKET, jts_pkg::ERR_NONE);
                        CH_RSQUARE: emit_token(jts_pkg::KIND_RBRACKET, jts_pkg::ERR_NONE);
                        CH_LCURLY:  emit_token(jts_pkg::KIND_LBRACE, jts_pkg::ERR_NONE);
                        CH_RCURLY:  emit_token(jts_pkg::KIND_RBRACE, jts_pkg::ERR_NONE);
                        CH_COMMA:   emit_token(jts_pkg::KIND_COMMA, jts_pkg::ERR_NONE);
                        CH_COLON:   emit_token(jts_pkg::KIND_COLON, jts_pkg::ERR_NONE);
                        default:
                        begin
                            if (is_alpha(c))
                            begin
                                mode     = S_WORD;
                                kw_live  = 6'h3F;
                                word_len = 3'd0;
                                add_letter(c);
                            end
                            else
                            begin
                                emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_UNEXP_CHAR);
                                mode = S_DISCARD;
                            end
                        end
                    endcase
                    return 1'b0;
                end
                S_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        emit_token(jts_pkg::KIND_STRING, jts_pkg::ERR_NONE);
                        mode = S_IDLE;
                        return 1'b0;
                    end
                    if (c == CH_COMMA || c == CH_COLON || c == CH_LF)
                    begin
                        emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_UNTERM_STR);
                        mode = S_DISCARD;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                S_INT, S_FRAC:
                begin
                    if (is_digit(c))
                        return 1'b0;
                    if (c == CH_DOT && mode == S_INT)
                    begin
                        mode = S_DOT;
                        return 1'b0;
                    end
                    if (c == CH_LOWER_E || c == CH_UPPER_E)
                    begin
                        mode = S_EMARK;
                        return 1'b0;
                    end
                    number_done = 1'b1;
                end
                S_DOT:
                begin
                    if (is_digit(c))
                    begin
                        mode = S_FRAC;
                        return 1'b0;
                    end
                    emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_BAD_NUMBER);
                    mode = S_DISCARD;
                    return 1'b1;
                end
                S_EMARK:
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        mode = S_ESIGN;
                        return 1'b0;
                    end
                    if (is_digit(c))
                    begin
                        mode = S_EXP;
                        return 1'b0;
                    end
                    emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_BAD_NUMBER);
                    mode = S_DISCARD;
                    return 1'b1;
                end
                S_ESIGN:
                begin
                    if (is_digit(c))
                    begin
                        mode = S_EXP;
                        return 1'b0;
                    end
                    emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_BAD_NUMBER);
                    mode = S_DISCARD;
                    return 1'b1;
                end
                S_EXP:
                begin
                    if (is_digit(c))
                        return 1'b0;
                    number_done = 1'b1;
                end
                S_WORD:
                begin
                    if (is_alpha(c))
                    begin
                        add_letter(c);
                        return 1'b0;
                    end
                    mode = close_word() ? S_IDLE : S_DISCARD;
                    return 1'b1;
                end
                default:
                begin
                    if (c == CH_LF)
                    begin
                        bump_line();
                        mode = S_IDLE;
                    end
                    return 1'b0;
                end
            endcase
            // a complete number has ended; a letter glued to it spoils it
            if (number_done && is_alpha(c))
            begin
                emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_BAD_NUMBER);
                mode = S_DISCARD;
                return 1'b0;
            end
            emit_token(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE);
            mode = S_IDLE;
            return 1'b1;
        endfunction

        // flush whatever is pending, then the end token
        function void close_source();
            case (mode)
                S_STRING:
                    emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_UNTERM_STR);
                S_INT, S_FRAC, S_EXP:
                    emit_token(jts_pkg::KIND_NUMBER, jts_pkg::ERR_NONE);
                S_DOT, S_EMARK, S_ESIGN:
                    emit_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_UNEXP_END);
                S_WORD:
                    void'(close_word());
                default: ;
            endcase
            emit_token(jts_pkg::KIND_END, jts_pkg::ERR_NONE);
            mode = S_IDLE;
            done = 1'b1;
        endfunction

        // accepted source word: work out the token words it causes
        function void note_word(logic [7:0] ch, logic eoi);
            if (done)
                return;
            step_res.delete();
            if (eoi)
                close_source();
            else if (scan_byte(ch))
                void'(scan_byte(ch));
            if (step_res.size() > 0)
                step_res[step_res.size() - 1].last = 1'b1;
            foreach (step_res[i])
                token_q.push_back(step_res[i]);
        endfunction

        function void match_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // accepted token word: compare with the oldest prediction
        function void check_word(logic [23:0] data, logic tlast);
            jts_pkg::result_t want;
            if (token_q.size() == 0)
            begin
                $error("token word with none outstanding: kind %0d line %0d",
                       data[3:0], data[22:7]);
                errors++;
                return;
            end
            want = token_q.pop_front();
            match_field("token_kind", want.kind, data[3:0]);
            match_field("error_kind", want.err, data[6:4]);
            match_field("line_number", want.line, data[22:7]);
            match_field("last", want.last, tlast);
            match_field("tdata pad", 0, data[23]);
        endfunction

    endclass

    // ------------------------------------------------------------------
    // Signals and the unit
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    token_scoreboard sb = new();

    logic [7:0]   text_q[$];     // bytes waiting to be sent
    int           burst_left   = 1;
    bit           steady       = 1'b0;   // hold tvalid high with no gaps
    int           cycle_no     = 0;
    ready_style_e ready_style  = READY_ALWAYS;

    json_token_scanner_unit #(
        .LINE_COUNT_BITS(16)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the unit's
    // registers move, so nothing hangs on event order within the step
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    // Receiver: switch between random stall patterns so that stalls land on
    // both halves of a two-token byte and on the queue filling up
    always @(negedge clk)
    begin
        cycle_no = cycle_no + 1;
        if (cycle_no % 97 == 0)
            ready_style = ready_style_e'($urandom_range(0, 3));
        case (ready_style)
            READY_ALWAYS:       m_axis_tready = 1'b1;
            READY_COIN:         m_axis_tready = 1'($urandom_range(0, 1));
            READY_TWO_IN_THREE: m_axis_tready = (cycle_no % 3) != 0;
            default:            m_axis_tready = (cycle_no % 8) < 2;
        endcase
    end

    // ------------------------------------------------------------------
    // Sender tasks; each is entered and left at a falling edge
    // ------------------------------------------------------------------

    // Present one word, hold it until taken, then maybe open a gap
    task automatic send_word(input logic [7:0] ch, input logic eoi);
        int gap;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tuser  = eoi;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            // a quarter of the bursts run straight on into the next
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_pending();
        while (text_q.size() > 0)
            send_word(text_q.pop_front(), 1'b0);
    endtask

    // Hold the source until every predicted token has come out
    task automatic drain_tokens();
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void push_digit();
        text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Close a number or word: mostly a delimiter, sometimes a letter glued on
    function automatic void push_separator();
        case ($urandom_range(0, 9))
            0:       text_q.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
            1, 2:    text_q.push_back(CH_COMMA);
            3, 4:    text_q.push_back(CH_LF);
            5:       text_q.push_back(CH_RSQUARE);
            6:       text_q.push_back(CH_TAB);
            default: text_q.push_back(CH_SPACE);
        endcase
    endfunction

    // Queue one random fragment: mostly well-formed tokens, some broken, some noise
    function automatic void push_fragment();
        int    pick;
        int    n;
        int    k;
        string word;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 5))
                0:       text_q.push_back(CH_LSQUARE);
                1:       text_q.push_back(CH_RSQUARE);
                2:       text_q.push_back(CH_LCURLY);
                3:       text_q.push_back(CH_RCURLY);
                4:       text_q.push_back(CH_COMMA);
                default: text_q.push_back(CH_COLON);
            endcase
        end
        else if (pick < 25)
        begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(CH_SPACE);
                1:       text_q.push_back(CH_TAB);
                2:       text_q.push_back(CH_CR);
                default: text_q.push_back(CH_LF);
            endcase
        end
        else if (pick < 40)
        begin
            // string with arbitrary content; one in seven is cut short
            text_q.push_back(CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE || b == CH_COMMA || b == CH_COLON || b == CH_LF)
                    b = CH_SPACE;
                text_q.push_back(b);
            end
            case ($urandom_range(0, 20))
                0:       text_q.push_back(CH_COMMA);
                1:       text_q.push_back(CH_COLON);
                2:       text_q.push_back(CH_LF);
                default: text_q.push_back(CH_QUOTE);
            endcase
        end
        else if (pick < 60)
        begin
            // number: digits, optional fraction, optional exponent; digit groups
            // after the point or the exponent mark are now and then left out
            repeat ($urandom_range(1, 4)) push_digit();
            if ($urandom_range(0, 1))
            begin
                text_q.push_back(CH_DOT);
                if ($urandom_range(0, 7) != 0)
                    repeat ($urandom_range(1, 3)) push_digit();
            end
            if ($urandom_range(0, 2) == 0)
            begin
                text_q.push_back($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
                case ($urandom_range(0, 2))
                    1:       text_q.push_back(CH_PLUS);
                    2:       text_q.push_back(CH_MINUS);
                    default: ;
                endcase
                if ($urandom_range(0, 7) != 0)
                    repeat ($urandom_range(1, 2)) push_digit();
            end
            push_separator();
        end
        else if (pick < 80)
        begin
            // keyword, sometimes truncated, mixed case or overlong
            k = $urandom_range(0, 5);
            word = sb.kw_text[k];
            for (int i = 0; i < word.len(); i++)
            begin
                b = word[i];
                case ($urandom_range(0, 29))
                    0:       b = b ^ 8'h20;
                    default: ;
                endcase
                if (!(i == word.len() - 1 && $urandom_range(0, 9) == 0))
                    text_q.push_back(b);
            end
            if ($urandom_range(0, 9) == 0)
                text_q.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
            push_separator();
        end
        else if (pick < 90)
        begin
            // arbitrary letters, long enough to pin the word length
            repeat ($urandom_range(1, 9))
                text_q.push_back(($urandom_range(0, 1) ? 8'h41 : CH_LOWER_A)
                                 + 8'($urandom_range(0, 25)));
            push_separator();
        end
        else
            text_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        string tails [11];
        int    sent;
        bit    paused;
        tails = '{"", "\"ab", "12", "3.", "4e", "5e-", "6.5e2", "null", "TRUE", "fals", "#"};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: all punctuation, a string, a full number, a keyword closed by a
        // control byte (two tokens from one byte), the byte extremes as stray chars
        push_text("[]{},:\"x\"9.0E-1 null");
        text_q.push_back(8'h00);
        text_q.push_back(CH_LF);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_LF);
        send_pending();
        drain_tokens();

        // Random fragments, with one full drain part way through
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_BYTES)
        begin
            push_fragment();
            sent += text_q.size();
            send_pending();
            if (!paused && sent >= RANDOM_BYTES / 2)
            begin
                drain_tokens();
                paused = 1'b1;
            end
        end

        // Line feeds back to back with no gaps, then a few tokens that must
        // report the line reached
        steady = 1'b1;
        repeat (LF_FLOOD) send_word(CH_LF, 1'b0);
        steady = 1'b0;
        push_text("[7,true]");
        text_q.push_back(CH_LF);
        send_pending();

        // End of source with a random token still open, then words that the
        // finished scanner must swallow
        text_q.push_back(CH_LF);
        push_text(tails[$urandom_range(0, 10)]);
        send_pending();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        repeat (3) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        s_axis_tvalid = 1'b0;

        drain_tokens();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
